[rtl/core/flood_dissemination_slot_step_top_defines.svh]
// Assertion macros shared by the flood dissemination slot step RTL.
`ifndef FLOOD_DISSEMINATION_SLOT_STEP_TOP_DEFINES_SVH
`define FLOOD_DISSEMINATION_SLOT_STEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define FDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fds: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define FDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fds: next-cycle check failed");

`else

`define FDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/fds_pkg.sv]
// Types and constants shared by the flood dissemination slot step block.
`timescale 1ns / 1ps

package fds_pkg;

    // Bitmap geometry and lane split
    localparam int FLAG_W    = 64;
    localparam int LANE_W    = 8;
    localparam int NUM_LANES = FLAG_W / LANE_W;
    localparam int COUNT_W   = 7;

    // Slot state codes of the finished slot
    localparam logic [1:0] SST_INIT = 2'd0;
    localparam logic [1:0] SST_RX   = 2'd1;
    localparam logic [1:0] SST_TX   = 2'd2;

    // Next state codes
    localparam logic [1:0] NS_RX  = 2'd0;
    localparam logic [1:0] NS_TX  = 2'd1;
    localparam logic [1:0] NS_OFF = 2'd2;

    // Item mode codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_SLOT  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_NODE_INDEX = 2'd1;
    localparam logic [1:0] CFG_INITIATOR  = 2'd2;

    // Restart threshold draw: 6 plus two random bits
    localparam logic [3:0] RESTART_MIN = 4'd6;
    localparam logic [3:0] RESTART_MAX = 4'd9;
    localparam logic [3:0] CNT_SAT    = 4'd15;

    // What one lane reports about its slice of the bitmap
    typedef struct packed {
        logic [LANE_W-1:0] merged;
        logic              diff_any;
        logic              merged_full;
        logic              rx_full;
    } lane_result_t;

    // Combined view over all lanes
    typedef struct packed {
        logic [FLAG_W-1:0] merged;
        logic              diff_any;
        logic              merged_full;
        logic              rx_full;
    } merge_summary_t;

endpackage

[rtl/core/fds_lane.sv]
// One bitmap lane: masked merge, difference and completeness tests on a slice.
`timescale 1ns / 1ps

module fds_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic [fds_pkg::COUNT_W-1:0] node_limit,
    input  logic [fds_pkg::LANE_W-1:0]  rx_bits,
    input  logic [fds_pkg::LANE_W-1:0]  merged_bits,
    output fds_pkg::lane_result_t       result
);
    import fds_pkg::*;

    logic [LANE_W-1:0] mask;
    logic [LANE_W-1:0] merged_new;

    // Build the node mask for the bits of this lane
    always_comb
    begin
        for (int j = 0; j < LANE_W; j++)
        begin
            mask[j] = (COUNT_W'(LANE_IDX * LANE_W + j) < node_limit);
        end
    end

    // Merge received bits and test the slice
    always_comb
    begin
        merged_new         = merged_bits | (rx_bits & mask);
        result.merged      = merged_new;
        result.diff_any    = |((rx_bits ^ merged_bits) & mask);
        result.merged_full = &(merged_new | ~mask);
        result.rx_full     = &(rx_bits | ~mask);
    end

endmodule

[rtl/core/fds_merge.sv]
// Combine lane results into one bitmap and three flags.
`timescale 1ns / 1ps

module fds_merge (
    input  fds_pkg::lane_result_t   lanes [fds_pkg::NUM_LANES],
    output fds_pkg::merge_summary_t summary
);
    import fds_pkg::*;

    // Concatenate bitmaps, OR the difference flags, AND the full flags
    always_comb
    begin
        summary.diff_any    = 1'b0;
        summary.merged_full = 1'b1;
        summary.rx_full     = 1'b1;
        summary.merged      = '0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            summary.merged[l*LANE_W +: LANE_W] = lanes[l].merged;
            summary.diff_any    = summary.diff_any | lanes[l].diff_any;
            summary.merged_full = summary.merged_full & lanes[l].merged_full;
            summary.rx_full     = summary.rx_full & lanes[l].rx_full;
        end
    end

endmodule

[rtl/core/flood_dissemination_slot_step_top.sv]
// Top level of the flood dissemination slot step engine.
// Usage:
//   Item channel (item_valid / item_stall): one transaction per finished slot,
//   or a round start when mode is 0. A transaction completes at a clock edge
//   with item_valid high and item_stall low.
//   Result channel (result_valid / result_stall): one result per item, in
//   order, with the next radio state and the round bookkeeping.
//   Config channel (cfg_valid / cfg_ready): write node_count (index 0),
//   node_index (index 1) or the initiator flag (index 2) while no item is
//   pending. cfg_ready is always high.
// Timing:
//   The bitmap is split over eight lanes of eight bits that merge and test
//   in parallel, and a merging stage folds their flags into one decision.
//   An item is decided in the cycle it is taken; its result is registered and
//   appears in the cycle after. One item per cycle is sustained while the result
//   side keeps up; the output register sets that rate.
// Reset and stall:
//   rst_n clears round state, config and result_valid; output data has no reset.
//   While a result is held with result_stall high, item_stall is raised and
//   no new item is taken until the result leaves.
`timescale 1ns / 1ps
`include "flood_dissemination_slot_step_top_defines.svh"

module flood_dissemination_slot_step_top #(
    parameter int MAX_NODES     = 64,
    parameter int ROUND_SLOTS   = 256,
    parameter int TX_DONE_COUNT = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    // config channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [1:0]  slot_state,
    input  logic        success,
    input  logic [15:0] slot_number,
    input  logic [31:0] in_value,
    input  logic [63:0] in_flags,
    input  logic [15:0] random_word,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  radio_mode,
    output logic [31:0] out_value,
    output logic [63:0] out_flags,
    output logic        complete,
    output logic [15:0] done_at_slot,
    output logic        end_of_round,
    output logic [15:0] end_slot
);
    import fds_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_N      = COUNT_W'(MAX_NODES);
    localparam logic [16:0]        END_THRESH = 17'(ROUND_SLOTS - 2);
    localparam logic [15:0]        SLOT_LIMIT = 16'(ROUND_SLOTS);
    localparam logic [3:0]         TX_DONE    = 4'(TX_DONE_COUNT);

    // Configuration registers
    logic [COUNT_W-1:0] node_count_reg;
    logic [5:0]         node_index_reg;
    logic               initiator_reg;

    // Round state
    logic [FLAG_W-1:0]  merged_flags_reg, merged_flags_next;
    logic [31:0]        held_value_reg, held_value_next;
    logic               want_tx_reg, want_tx_next;
    logic               done_reg, done_next;
    logic [15:0]        done_slot_reg, done_slot_next;
    logic               saw_full_reg, saw_full_next;
    logic [3:0]         tx_after_done_reg, tx_after_done_next;
    logic [3:0]         missed_rx_reg, missed_rx_next;
    logic               had_valid_rx_reg, had_valid_rx_next;
    logic [3:0]         restart_limit_reg, restart_limit_next;
    logic [15:0]        end_slot_reg, end_slot_next;

    // Output register
    logic               result_valid_reg;
    logic [1:0]         radio_mode_reg, radio_mode_next;
    logic [FLAG_W-1:0]  out_flags_reg, out_flags_next;
    logic               end_of_round_reg, end_of_round_next;

    logic               item_take;
    logic [COUNT_W-1:0] node_limit;
    lane_result_t       lane_res [NUM_LANES];
    merge_summary_t     summary;

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign item_stall = result_valid_reg & result_stall;
    assign item_take  = item_valid & ~item_stall;

    // Saturate node count at the bitmap size
    assign node_limit = (node_count_reg > MAX_N) ? MAX_N : node_count_reg;

    // Lanes over the bitmap
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        fds_lane #(
            .LANE_IDX(l)
        ) u_lane (
            .node_limit  (node_limit),
            .rx_bits     (in_flags[l*LANE_W +: LANE_W]),
            .merged_bits (merged_flags_reg[l*LANE_W +: LANE_W]),
            .result      (lane_res[l])
        );
    end

    fds_merge u_merge (
        .lanes   (lane_res),
        .summary (summary)
    );

    // Decide the slot and update the round state
    always_comb
    begin
        logic rx;
        logic txs;
        logic merge_take;
        logic [3:0] missed_inc;

        rx         = (slot_state == SST_RX);
        txs        = (slot_state == SST_TX);
        merge_take = ~done_reg & success & rx;
        missed_inc = missed_rx_reg + 4'd1;

        merged_flags_next  = merged_flags_reg;
        held_value_next    = held_value_reg;
        want_tx_next       = want_tx_reg;
        done_next          = done_reg;
        done_slot_next     = done_slot_reg;
        saw_full_next      = saw_full_reg;
        tx_after_done_next = tx_after_done_reg;
        missed_rx_next     = missed_rx_reg;
        had_valid_rx_next  = had_valid_rx_reg;
        restart_limit_next = restart_limit_reg;
        end_slot_next      = end_slot_reg;
        radio_mode_next    = NS_RX;
        end_of_round_next  = 1'b0;
        out_flags_next     = in_flags;

        if (mode == MODE_START)
        begin
            // Start a new round
            want_tx_next       = 1'b0;
            had_valid_rx_next  = 1'b0;
            done_next          = 1'b0;
            tx_after_done_next = '0;
            missed_rx_next     = '0;
            end_slot_next      = SLOT_LIMIT;
            done_slot_next     = '0;
            saw_full_next      = 1'b0;
            restart_limit_next = RESTART_MIN + {2'b00, random_word[1:0]};
            held_value_next    = initiator_reg ? in_value : 32'd0;
            merged_flags_next  = FLAG_W'(1) << node_index_reg;
            out_flags_next     = FLAG_W'(1) << node_index_reg;
        end
        else
        begin
            // Merge a good reception before completion
            if (merge_take)
            begin
                had_valid_rx_next = 1'b1;
                held_value_next   = in_value;
                merged_flags_next = summary.merged;
                want_tx_next      = summary.diff_any | summary.merged_full;
                if (summary.merged_full)
                begin
                    done_next      = 1'b1;
                    done_slot_next = slot_number;
                end
            end
            else if (done_reg & success & rx & summary.rx_full)
            begin
                saw_full_next = 1'b1;
            end

            // Pick the next radio state
            if (initiator_reg && slot_state == SST_INIT)
            begin
                radio_mode_next   = NS_TX;
                had_valid_rx_next = 1'b1;
            end
            else if (rx && success)
            begin
                missed_rx_next = '0;
                if (want_tx_next)
                begin
                    radio_mode_next = NS_TX;
                    if (done_next && tx_after_done_reg != CNT_SAT)
                        tx_after_done_next = tx_after_done_reg + 4'd1;
                end
            end
            else if (rx && !success && had_valid_rx_next)
            begin
                missed_rx_next = missed_inc;
                if (missed_inc > restart_limit_reg)
                begin
                    radio_mode_next    = NS_TX;
                    missed_rx_next     = '0;
                    restart_limit_next = RESTART_MIN + {2'b00, random_word[1:0]};
                    if (done_next && tx_after_done_reg != CNT_SAT)
                        tx_after_done_next = tx_after_done_reg + 4'd1;
                end
            end
            else if (txs && !success)
            begin
                had_valid_rx_next = 1'b1;
                radio_mode_next   = NS_TX;
            end
            else if (txs && saw_full_next && tx_after_done_reg >= TX_DONE)
            begin
                radio_mode_next = NS_OFF;
            end

            // Mark the end of the round
            end_of_round_next = ({1'b0, slot_number} >= END_THRESH) ||
                                (radio_mode_next == NS_OFF);
            if (end_of_round_next)
                end_slot_next = slot_number;
            out_flags_next = txs ? merged_flags_next : in_flags;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 7'd64;
            node_index_reg <= '0;
            initiator_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data;
                CFG_NODE_INDEX: node_index_reg <= cfg_data[5:0];
                CFG_INITIATOR:  initiator_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Advance the round state on each taken item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merged_flags_reg  <= '0;
            held_value_reg    <= '0;
            want_tx_reg       <= 1'b0;
            done_reg          <= 1'b0;
            done_slot_reg     <= '0;
            saw_full_reg      <= 1'b0;
            tx_after_done_reg <= '0;
            missed_rx_reg     <= '0;
            had_valid_rx_reg  <= 1'b0;
            restart_limit_reg <= RESTART_MIN;
            end_slot_reg      <= SLOT_LIMIT;
        end
        else if (item_take)
        begin
            merged_flags_reg  <= merged_flags_next;
            held_value_reg    <= held_value_next;
            want_tx_reg       <= want_tx_next;
            done_reg          <= done_next;
            done_slot_reg     <= done_slot_next;
            saw_full_reg      <= saw_full_next;
            tx_after_done_reg <= tx_after_done_next;
            missed_rx_reg     <= missed_rx_next;
            had_valid_rx_reg  <= had_valid_rx_next;
            restart_limit_reg <= restart_limit_next;
            end_slot_reg      <= end_slot_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (item_take)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            radio_mode_reg   <= radio_mode_next;
            out_flags_reg    <= out_flags_next;
            end_of_round_reg <= end_of_round_next;
        end
    end

    // Result ports: state fields read straight from the round registers
    assign result_valid = result_valid_reg;
    assign radio_mode   = radio_mode_reg;
    assign out_value    = held_value_reg;
    assign out_flags    = out_flags_reg;
    assign complete     = done_reg;
    assign done_at_slot = done_slot_reg;
    assign end_of_round = end_of_round_reg;
    assign end_slot     = end_slot_reg;

    // Checks
    `FDS_ASSERT_NEXT(a_take_gives_result, clk, rst_n, item_take, result_valid_reg)
    `FDS_ASSERT_IMPLY(a_off_ends_round, clk, rst_n, result_valid_reg && radio_mode_reg == NS_OFF, end_of_round_reg)
    `FDS_ASSERT_IMPLY(a_slot_needs_done, clk, rst_n, !done_reg, done_slot_reg == 16'd0)
    `FDS_ASSERT_IMPLY(a_limit_range, clk, rst_n, 1'b1, restart_limit_reg >= RESTART_MIN && restart_limit_reg <= RESTART_MAX)

endmodule

[bench/flood_dissemination_slot_step_top_test.sv]
// Testbench for the flood dissemination slot step engine.
`timescale 1ns / 1ps

module flood_dissemination_slot_step_top_test;
    import fds_pkg::*;

    localparam int MAX_NODES     = 64;
    localparam int ROUND_SLOTS   = 256;
    localparam int TX_DONE_COUNT = 9;
    localparam int STALL_LIMIT   = 2000;

    // Slot state code that matches no radio state
    localparam logic [1:0] SST_UNUSED = 2'd3;

    typedef struct {
        logic        mode;
        logic [1:0]  slot_state;
        logic        success;
        logic [15:0] slot_number;
        logic [31:0] value;
        logic [63:0] flags;
        logic [15:0] rnd;
    } slot_item_t;

    typedef struct {
        logic [1:0]  radio_mode;
        logic [31:0] value;
        logic [63:0] flags;
        logic        complete;
        logic [15:0] done_at_slot;
        logic        end_of_round;
        logic [15:0] end_slot;
    } slot_decision_t;

    typedef struct {
        logic [63:0] merged;
        logic [31:0] value;
        logic        want_tx;
        logic        done;
        logic [15:0] done_slot;
        logic        saw_full;
        logic [3:0]  tx_done;
        logic [3:0]  missed;
        logic        had_rx;
        logic [3:0]  limit;
        logic [15:0] end_slot;
    } round_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        mode = 1'b0;
    logic [1:0]  slot_state = '0;
    logic        success = 1'b0;
    logic [15:0] slot_number = '0;
    logic [31:0] in_value = '0;
    logic [63:0] in_flags = '0;
    logic [15:0] random_word = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  radio_mode;
    logic [31:0] out_value;
    logic [63:0] out_flags;
    logic        complete;
    logic [15:0] done_at_slot;
    logic        end_of_round;
    logic [15:0] end_slot;

    // Predictor copy of the registers and the round
    logic [6:0]   set_node_count;
    logic [5:0]   set_node_index;
    logic         set_initiator;
    round_state_t flood;
    logic [1:0]   last_next = NS_RX;

    slot_decision_t pending_decisions[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int rounds_run = 0;
    int config_writes = 0;
    int completions_seen = 0;
    int offs_seen = 0;
    int idle_cycles = 0;

    flood_dissemination_slot_step_top #(
        .MAX_NODES     (MAX_NODES),
        .ROUND_SLOTS   (ROUND_SLOTS),
        .TX_DONE_COUNT (TX_DONE_COUNT)
    ) i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Randomly stall the result side
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Put the predictor into its reset state
    task automatic reset_model();
        set_node_count = 7'd64;
        set_node_index = 6'd0;
        set_initiator  = 1'b0;
        flood = '{merged: '0, value: '0, want_tx: 1'b0, done: 1'b0, done_slot: '0,
                  saw_full: 1'b0, tx_done: '0, missed: '0, had_rx: 1'b0,
                  limit: RESTART_MIN, end_slot: 16'(ROUND_SLOTS)};
    endtask

    // Bits of the participating nodes, count saturated at the bitmap width
    function automatic logic [63:0] member_mask();
        int n;
        n = (set_node_count > MAX_NODES) ? MAX_NODES : int'(set_node_count);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic void count_tx_after_done();
        if (flood.done && flood.tx_done != CNT_SAT)
            flood.tx_done = flood.tx_done + 4'd1;
    endfunction

    // Advance the round by one item and return the decision it produces
    function automatic slot_decision_t decide_slot(input slot_item_t it);
        slot_decision_t d;
        logic [63:0] mask;
        logic [1:0]  nxt;
        logic        ended;
        logic        is_rx;
        logic        is_tx;
        mask  = member_mask();
        nxt   = NS_RX;
        ended = 1'b0;
        if (it.mode == MODE_START)
        begin
            flood.want_tx   = 1'b0;
            flood.had_rx    = 1'b0;
            flood.done      = 1'b0;
            flood.tx_done   = '0;
            flood.missed    = '0;
            flood.end_slot  = 16'(ROUND_SLOTS);
            flood.done_slot = '0;
            flood.saw_full  = 1'b0;
            flood.limit     = RESTART_MIN + {2'b00, it.rnd[1:0]};
            flood.value     = set_initiator ? it.value : 32'd0;
            flood.merged    = 64'd1 << set_node_index;
            d.flags         = flood.merged;
        end
        else
        begin
            is_rx = (it.slot_state == SST_RX);
            is_tx = (it.slot_state == SST_TX);
            // Merge a good reception, or note a full packet after completion
            if (!flood.done && it.success && is_rx)
            begin
                flood.had_rx  = 1'b1;
                flood.value   = it.value;
                flood.want_tx = ((it.flags ^ flood.merged) & mask) != 0;
                flood.merged  = flood.merged | (it.flags & mask);
                if ((flood.merged & mask) == mask)
                begin
                    flood.want_tx   = 1'b1;
                    flood.done_slot = it.slot_number;
                    flood.done      = 1'b1;
                end
            end
            else if (flood.done && it.success && is_rx)
            begin
                if ((it.flags & mask) == mask)
                    flood.saw_full = 1'b1;
            end
            // Pick the next radio state
            if (set_initiator && it.slot_state == SST_INIT)
            begin
                nxt = NS_TX;
                flood.had_rx = 1'b1;
            end
            else if (is_rx && it.success)
            begin
                flood.missed = '0;
                if (flood.want_tx)
                begin
                    nxt = NS_TX;
                    count_tx_after_done();
                end
            end
            else if (is_rx && !it.success && flood.had_rx)
            begin
                flood.missed = flood.missed + 4'd1;
                if (flood.missed > flood.limit)
                begin
                    nxt = NS_TX;
                    flood.missed = '0;
                    count_tx_after_done();
                    flood.limit = RESTART_MIN + {2'b00, it.rnd[1:0]};
                end
            end
            else if (is_tx && !it.success)
            begin
                flood.had_rx = 1'b1;
                nxt = NS_TX;
            end
            else if (is_tx && flood.saw_full && flood.tx_done >= TX_DONE_COUNT)
            begin
                nxt = NS_OFF;
            end
            ended = (int'(it.slot_number) >= ROUND_SLOTS - 2) || nxt == NS_OFF;
            if (ended)
                flood.end_slot = it.slot_number;
            d.flags = is_tx ? flood.merged : it.flags;
        end
        d.radio_mode   = nxt;
        d.value        = flood.value;
        d.complete     = flood.done;
        d.done_at_slot = flood.done_slot;
        d.end_of_round = ended;
        d.end_slot     = flood.end_slot;
        return d;
    endfunction

    function automatic slot_item_t make_item(input logic m, input logic [1:0] sst,
                                             input logic ok, input logic [15:0] slot,
                                             input logic [31:0] value,
                                             input logic [63:0] flags,
                                             input logic [15:0] rnd);
        slot_item_t it;
        it = '{mode: m, slot_state: sst, success: ok, slot_number: slot, value: value,
               flags: flags, rnd: rnd};
        return it;
    endfunction

    function automatic slot_item_t random_item();
        return make_item(1'($urandom), 2'($urandom), 1'($urandom), 16'($urandom),
                         $urandom, {$urandom, $urandom}, 16'($urandom));
    endfunction

    // Offer one item, hold it until taken, then log its expected decision
    task automatic send_item(input slot_item_t it);
        slot_decision_t d;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        mode        <= it.mode;
        slot_state  <= it.slot_state;
        success     <= it.success;
        slot_number <= it.slot_number;
        in_value    <= it.value;
        in_flags    <= it.flags;
        random_word <= it.rnd;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        d = decide_slot(it);
        last_next = d.radio_mode;
        pending_decisions.push_back(d);
        items_sent++;
    endtask

    // Drop the item valid and wait until every decision has come back
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_decisions.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_NODE_COUNT: set_node_count = data;
            CFG_NODE_INDEX: set_node_index = data[5:0];
            CFG_INITIATOR:  set_initiator  = data[0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [6:0] count, input logic [5:0] idx,
                                input logic init);
        write_reg(CFG_NODE_COUNT, count);
        write_reg(CFG_NODE_INDEX, {1'b0, idx});
        write_reg(CFG_INITIATOR, {6'd0, init});
        cfg_valid <= 1'b0;
        config_writes++;
    endtask

    // Reset registers: full 64-node mask, own bit 0, not the initiator
    task automatic test_reset_defaults();
        send_item(make_item(MODE_START, SST_INIT, 1'b1, 16'd0, 32'hFFFF_FFFF, '1,
                            16'hFFFF));
        send_item(make_item(MODE_SLOT, SST_INIT, 1'b0, 16'd0, 32'h0, '0, 16'h0));
        send_item(make_item(MODE_SLOT, SST_UNUSED, 1'b1, 16'd1, 32'hA5A5_5A5A, '1,
                            16'h1));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b0, 16'd2, 32'h1, 64'h1, 16'h2));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b1, 16'd3, 32'h0, '0, 16'h3));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, '1,
                            16'h0));
        send_item(make_item(MODE_SLOT, SST_TX, 1'b0, 16'd5, 32'h0, 64'h5555, 16'h0));
        send_item(make_item(MODE_SLOT, SST_TX, 1'b1, 16'd6, 32'h0, 64'hAAAA, 16'h0));
    endtask

    // Empty mask on the initiator: any good reception completes the round
    task automatic test_initiator_empty_mask();
        drain();
        write_config(7'd0, 6'd63, 1'b1);
        send_item(make_item(MODE_START, SST_RX, 1'b0, 16'd0, 32'hDEAD_BEEF, '0, 16'h0));
        send_item(make_item(MODE_SLOT, SST_INIT, 1'b1, 16'd0, 32'h0, '0, 16'h0));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b1, 16'd1, 32'h1234_5678,
                            64'hF0F0_0000_0000_0F0F, 16'h0));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b1, 16'd2, 32'h0, '0, 16'h0));
        send_item(make_item(MODE_SLOT, SST_TX, 1'b1, 16'd0, 32'h0, '0, 16'h0));
    endtask

    // Count above 64 acts as 64
    task automatic test_count_saturation();
        drain();
        write_config(7'd127, 6'd5, 1'b0);
        send_item(make_item(MODE_START, SST_TX, 1'b1, 16'd0, 32'h0, '0, 16'h2));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b1, 16'd1, 32'h7,
                            ~(64'd1 << 5), 16'h0));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b0, 16'd2, 32'h0, '0, 16'h0));
    endtask

    // Own bit outside the mask is kept in the bitmap but never tested
    task automatic test_own_bit_outside_mask();
        drain();
        write_config(7'd3, 6'd40, 1'b0);
        send_item(make_item(MODE_START, SST_RX, 1'b1, 16'd0, 32'h0, '0, 16'h1));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b1, 16'd1, 32'h11, 64'h3, 16'h0));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b1, 16'd2, 32'h22, 64'h4, 16'h0));
        send_item(make_item(MODE_SLOT, SST_TX, 1'b1, 16'd254, 32'h0, '0, 16'h0));
        send_item(make_item(MODE_SLOT, SST_RX, 1'b1, 16'd3, 32'h33,
                            64'hFFFF_FFFF_FFFF_FFF8, 16'h0));
    endtask

    // Pick a register setting, leaning on the extremes
    task automatic random_config();
        logic [6:0] count;
        logic [5:0] idx;
        case ($urandom_range(9))
            0:       count = 7'd0;
            1:       count = 7'd1;
            2:       count = 7'd64;
            3:       count = 7'($urandom_range(65, 127));
            4, 5:    count = 7'($urandom_range(1, 8));
            default: count = 7'($urandom_range(1, 64));
        endcase
        if (count != 0 && count < 64 && $urandom_range(3) != 0)
            idx = 6'($urandom_range(int'(count) - 1));
        else
            idx = 6'($urandom);
        write_config(count, idx, 1'($urandom));
    endtask

    // One round that follows the block's own next-state choice, with some noise
    task automatic run_round(input int max_slots);
        slot_item_t  it;
        logic [63:0] mask;
        int          base;
        int          s;
        mask = member_mask();
        base = ($urandom_range(9) == 0) ? 240 : 0;
        it = random_item();
        it.mode = MODE_START;
        send_item(it);
        for (s = 0; s < max_slots && last_next != NS_OFF; s++)
        begin
            it = random_item();
            if ($urandom_range(99) >= 8)
            begin
                it.mode = MODE_SLOT;
                it.slot_number = 16'(base + s);
                if (s == 0)
                    it.slot_state = SST_INIT;
                else if (last_next == NS_TX)
                    it.slot_state = SST_TX;
                else
                    it.slot_state = SST_RX;
                it.success = ($urandom_range(99) < 70);
                if ($urandom_range(3) == 0)
                    it.flags = it.flags | mask;
            end
            send_item(it);
        end
        rounds_run++;
    endtask

    task automatic test_random_rounds(input int tx_idle, input int rx_idle,
                                      input int target);
        int first;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        first = items_sent;
        while (items_sent - first < target)
        begin
            drain();
            random_config();
            run_round($urandom_range(20, 60));
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transaction with the oldest expected decision
    always @(posedge clk)
    begin : check_results
        slot_decision_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_decisions.size() == 0)
            begin
                $error("result arrived with no decision pending");
                mismatches++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                check_field("radio_mode", want.radio_mode, radio_mode);
                check_field("out_value", want.value, out_value);
                check_field("out_flags", want.flags, out_flags);
                check_field("complete", want.complete, complete);
                check_field("done_at_slot", want.done_at_slot, done_at_slot);
                check_field("end_of_round", want.end_of_round, end_of_round);
                check_field("end_slot", want.end_slot, end_slot);
                results_checked++;
                if (want.complete)
                    completions_seen++;
                if (want.radio_mode == NS_OFF)
                    offs_seen++;
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_stall === 1'b0) ||
                (result_valid === 1'b1 && !result_stall) ||
                (cfg_valid && cfg_ready === 1'b1))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transaction", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 36;
        recv_idle_pct = 50;
        test_reset_defaults();
        test_initiator_empty_mask();
        test_count_saturation();
        test_own_bit_outside_mask();
        test_random_rounds(36, 50, 280);
        test_random_rounds(50, 36, 280);
        test_random_rounds(0, 0, 280);
        drain();
        repeat (4) @(posedge clk);
        $display("Run: %0d items in %0d random rounds, %0d register settings, %0d checked.",
                 items_sent, rounds_run, config_writes, results_checked);
        $display("Decisions with the round complete: %0d, switch-off decisions: %0d.",
                 completions_seen, offs_seen);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
